@@ design/cifd_pkg.sv @@
// ----------------------------------------------------------------------------
// cifd_pkg
// shared types, codes and constants of the compact integer field decoder
// ----------------------------------------------------------------------------
package cifd_pkg;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 3;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_INT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UINT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BOOL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd3;

  // field kinds
  localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOOL = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  localparam logic [BYTE_W-1:0]  ESC_16   = 8'h80;
  localparam logic [BYTE_W-1:0]  ESC_32   = 8'h81;
  localparam logic [VALUE_W-1:0] TOP_FILL = 32'hF000_0000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INT  = 2'd1,
    PH_UINT = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   pending;
    logic [VALUE_W-1:0] partial;
    logic [CNT_W-1:0]   taken;
  } dec_state_t;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
  } dec_result_t;

endpackage

@@ design/cifd_in_if.sv @@
// ----------------------------------------------------------------------------
// cifd_in_if
// byte channel into the decoder: command and raw data byte
// ----------------------------------------------------------------------------
interface cifd_in_if;
  import cifd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ design/cifd_out_if.sv @@
// ----------------------------------------------------------------------------
// cifd_out_if
// decoded field channel: value, kind and status
// ----------------------------------------------------------------------------
interface cifd_out_if;
  import cifd_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [KIND_W-1:0]   kind;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output value, output kind, output status, input ready);
  modport sink   (input valid, input value, input kind, input status, output ready);
endinterface

@@ design/cifd_decode.sv @@
// ----------------------------------------------------------------------------
// cifd_decode
// one-byte step of the field decoder: next state and optional result
// ----------------------------------------------------------------------------
module cifd_decode (
  input  cifd_pkg::dec_state_t        state,
  input  logic [cifd_pkg::CMD_W-1:0]  cmd,
  input  logic [cifd_pkg::BYTE_W-1:0] data_byte,
  output cifd_pkg::dec_state_t        state_nxt,
  output cifd_pkg::dec_result_t       result
);
  import cifd_pkg::*;

  localparam dec_state_t IDLE_STATE = '{phase: PH_IDLE, pending: '0, partial: '0, taken: '0};

  logic [VALUE_W-1:0] byte_ext;
  logic [VALUE_W-1:0] int_part;
  logic [VALUE_W-1:0] grp_part;
  logic [VALUE_W-1:0] grp_ext;
  logic [CNT_W-1:0]   pending_dec;

  assign byte_ext    = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
  assign grp_ext     = {{(VALUE_W-BYTE_W+1){1'b0}}, data_byte[BYTE_W-2:0]};
  assign pending_dec = state.pending - CNT_W'(1);

  // escaped int payload byte placement
  always_comb begin
    case (state.taken[1:0])
      2'd0:    int_part = state.partial | byte_ext;
      2'd1:    int_part = state.partial | (byte_ext << 8);
      2'd2:    int_part = state.partial | (byte_ext << 16);
      default: int_part = state.partial | (byte_ext << 24);
    endcase
  end

  // uint group placement
  always_comb begin
    case (state.taken[1:0])
      2'd0:    grp_part = state.partial | grp_ext;
      2'd1:    grp_part = state.partial | (grp_ext << 7);
      2'd2:    grp_part = state.partial | (grp_ext << 14);
      default: grp_part = state.partial | (grp_ext << 21);
    endcase
  end

  always_comb begin
    state_nxt = state;
    result    = '{emit: 1'b0, value: '0, kind: KIND_INT, status: ST_OK};
    if (cmd == CMD_END) begin
      if (state.phase != PH_IDLE) begin
        state_nxt = IDLE_STATE;
        result    = '{emit: 1'b1, value: '0,
                      kind: (state.phase == PH_INT) ? KIND_INT : KIND_UINT,
                      status: ST_EOS};
      end
    end else begin
      unique case (state.phase)
        PH_INT: begin
          if (pending_dec == '0) begin
            state_nxt = IDLE_STATE;
            result    = '{emit: 1'b1, value: int_part, kind: KIND_INT, status: ST_OK};
          end else begin
            state_nxt.partial = int_part;
            state_nxt.taken   = state.taken + CNT_W'(1);
            state_nxt.pending = pending_dec;
          end
        end
        PH_UINT: begin
          if (state.taken[1:0] == 2'd3) begin
            state_nxt = IDLE_STATE;
            result    = '{emit: 1'b1,
                          value: data_byte[BYTE_W-1] ? (grp_part | TOP_FILL) : grp_part,
                          kind: KIND_UINT, status: ST_OK};
          end else if (data_byte[BYTE_W-1]) begin
            state_nxt.partial = grp_part;
            state_nxt.taken   = state.taken + CNT_W'(1);
          end else begin
            state_nxt = IDLE_STATE;
            result    = '{emit: 1'b1, value: grp_part, kind: KIND_UINT, status: ST_OK};
          end
        end
        PH_IDLE: begin
          case (cmd)
            CMD_INT: begin
              if (data_byte == ESC_16 || data_byte == ESC_32) begin
                state_nxt = '{phase: PH_INT,
                              pending: (data_byte == ESC_16) ? CNT_W'(2) : CNT_W'(4),
                              partial: '0, taken: '0};
              end else begin
                result = '{emit: 1'b1, value: byte_ext, kind: KIND_INT, status: ST_OK};
              end
            end
            CMD_UINT: begin
              if (data_byte[BYTE_W-1]) begin
                state_nxt = '{phase: PH_UINT, pending: '0, partial: grp_ext,
                              taken: CNT_W'(1)};
              end else begin
                result = '{emit: 1'b1, value: byte_ext, kind: KIND_UINT, status: ST_OK};
              end
            end
            default: begin
              if (data_byte > BYTE_W'(1)) begin
                result = '{emit: 1'b1, value: '0, kind: KIND_BOOL, status: ST_BAD};
              end else begin
                result = '{emit: 1'b1, value: byte_ext, kind: KIND_BOOL, status: ST_OK};
              end
            end
          endcase
        end
        default: begin
          state_nxt = IDLE_STATE;
        end
      endcase
    end
  end

endmodule

@@ design/compact_integer_field_decoder.sv @@
// ----------------------------------------------------------------------------
// compact_integer_field_decoder
// byte-serial decoder of escaped ints, 7-bit group uints and bools
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                        notes
//   in_ch    sink       cmd[1:0], data_byte[7:0]       one byte per transaction
//   out_ch   source     value[31:0], kind, status      zero or one per input
//
// one byte per cycle sustained while the output is not stalled; a byte waits
// in the input register, and its result, if any, is registered as it moves on
// field state (phase, counters, partial value) updates when a byte moves on
// an output stall holds the input register; in_ready stays high while it is free
// rst_n is synchronous and clears valid bits and field state
//
module compact_integer_field_decoder (
  input logic        clk,
  input logic        rst_n,
  cifd_in_if.sink    in_ch,
  cifd_out_if.source out_ch
);
  import cifd_pkg::*;

  // input register
  logic              in_valid_r;
  logic [CMD_W-1:0]  in_cmd_r;
  logic [BYTE_W-1:0] in_byte_r;

  // field state carried between bytes
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t result;

  // result register
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [STATUS_W-1:0] out_status_r;

  logic out_free;
  logic advance;

  // output slot is free when empty or being drained this cycle
  assign out_free     = !out_valid_r || out_ch.ready;
  // a byte leaves the input register only when the result slot is free,
  // whether or not the byte finishes a field
  assign advance      = in_valid_r && out_free;
  assign in_ch.ready  = !in_valid_r || advance;

  cifd_decode u_decode (
    .state     (state_r),
    .cmd       (in_cmd_r),
    .data_byte (in_byte_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r  <= in_ch.cmd;
      in_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, pending: '0, partial: '0, taken: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_value_r  <= result.value;
      out_kind_r   <= result.kind;
      out_status_r <= result.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.status = out_status_r;

`ifndef SYNTH
  // an error result never carries a value
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // a good bool is zero or one
  a_bool_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_BOOL && out_status_r == ST_OK
      |-> out_value_r <= VALUE_W'(1))
    else $error("bool result out of range");

  // idle field state holds no leftovers
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDLE |-> state_r.pending == '0 && state_r.partial == '0
      && state_r.taken == '0)
    else $error("idle state not clean");

  // an escaped int always owes at least one byte
  a_int_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_INT |-> state_r.pending != '0)
    else $error("int escape with nothing pending");
`endif

endmodule

@@ tb/tb_compact_integer_field_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_compact_integer_field_decoder
// self-checking bench for the byte-serial field decoder: a directed burst of
// field extremes and corner cases, then random well-formed and broken fields
// under shifting sender and receiver idling, each result checked in order
// ----------------------------------------------------------------------------
module tb_compact_integer_field_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import cifd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_REPORTS = 10;
  localparam int ITEM_TARGET = 1100;

  // one decoded field as it leaves the block
  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
  } field_rec_t;

  // --------------------------------------------------------------------------
  // field tracker: mirrors the decoder state and keeps the queue of fields
  // still owed by the block
  // --------------------------------------------------------------------------
  class field_tracker;
    phase_t             phase;
    logic [CNT_W-1:0]   owed;
    logic [VALUE_W-1:0] acc;
    logic [CNT_W-1:0]   got;
    field_rec_t         fields_owed[$];
    int                 errors;
    int                 checked;
    int                 n_ok;
    int                 n_eos;
    int                 n_bad;

    function new();
      phase   = PH_IDLE;
      owed    = '0;
      acc     = '0;
      got     = '0;
      errors  = 0;
      checked = 0;
      n_ok    = 0;
      n_eos   = 0;
      n_bad   = 0;
    endfunction

    // a field finishes: queue it and fall back to idle
    function void close_field(logic [VALUE_W-1:0] v, logic [KIND_W-1:0] k,
                              logic [STATUS_W-1:0] s);
      field_rec_t rec;
      rec.value  = v;
      rec.kind   = k;
      rec.status = s;
      fields_owed.push_back(rec);
      phase = PH_IDLE;
      owed  = '0;
      acc   = '0;
      got   = '0;
    endfunction

    // an accepted byte transaction
    function void take_byte(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] b);
      logic [1:0] grp;
      if (c == CMD_END) begin
        if (phase == PH_INT) close_field('0, KIND_INT, ST_EOS);
        else if (phase == PH_UINT) close_field('0, KIND_UINT, ST_EOS);
        return;
      end
      case (phase)
        PH_INT: begin
          acc  = acc | ({24'd0, b} << (8 * got[1:0]));
          got  = got + 3'd1;
          owed = owed - 3'd1;
          if (owed == '0) close_field(acc, KIND_INT, ST_OK);
        end
        PH_UINT: begin
          grp = got[1:0];
          acc = acc | ({25'd0, b[6:0]} << (7 * grp));
          if (grp == 2'd3) begin
            if (b[7]) acc = acc | TOP_FILL;
            close_field(acc, KIND_UINT, ST_OK);
          end else if (b[7]) begin
            got = got + 3'd1;
          end else begin
            close_field(acc, KIND_UINT, ST_OK);
          end
        end
        default: begin
          if (c == CMD_INT) begin
            if (b == ESC_16 || b == ESC_32) begin
              phase = PH_INT;
              owed  = (b == ESC_16) ? 3'd2 : 3'd4;
              got   = '0;
              acc   = '0;
            end else begin
              close_field({24'd0, b}, KIND_INT, ST_OK);
            end
          end else if (c == CMD_UINT) begin
            if (b[7]) begin
              phase = PH_UINT;
              acc   = {25'd0, b[6:0]};
              got   = 3'd1;
              owed  = '0;
            end else begin
              close_field({24'd0, b}, KIND_UINT, ST_OK);
            end
          end else begin
            if (b > 8'd1) close_field('0, KIND_BOOL, ST_BAD);
            else close_field({24'd0, b}, KIND_BOOL, ST_OK);
          end
        end
      endcase
    endfunction

    // an accepted result transaction against the oldest owed field
    function void match_field(logic [VALUE_W-1:0] v, logic [KIND_W-1:0] k,
                              logic [STATUS_W-1:0] s);
      field_rec_t want;
      checked++;
      if (fields_owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected field value=%h kind=%0d status=%0d", $realtime, v, k, s);
        return;
      end
      want = fields_owed.pop_front();
      if (want.status == ST_OK) n_ok++;
      else if (want.status == ST_EOS) n_eos++;
      else n_bad++;
      if (v !== want.value || k !== want.kind || s !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: field mismatch exp value=%h kind=%0d status=%0d",
                   $realtime, want.value, want.kind, want.status);
          $display("    got value=%h kind=%0d status=%0d", v, k, s);
        end
      end
    endfunction

    function int waiting();
      return fields_owed.size();
    endfunction

    // anything still owed at the end is a failure
    function void flag_leftovers();
      if (fields_owed.size() != 0) begin
        errors += fields_owed.size();
        $display("%0t: %0d fields never arrived", $realtime, fields_owed.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #CLK_HALF clk = ~clk;

  cifd_in_if  in_bus ();
  cifd_out_if out_bus ();

  compact_integer_field_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  field_tracker tracker;

  int in_gap_pct    = 0;   // chance per cycle that the sender idles
  int out_stall_pct = 0;   // chance per cycle that the receiver stalls
  int bytes_sent    = 0;
  int cycle_count   = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitors: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        tracker.take_byte(in_bus.cmd, in_bus.data_byte);
      if (out_bus.valid && out_bus.ready)
        tracker.match_field(out_bus.value, out_bus.kind, out_bus.status);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request so the
  // block backs up and drops in_ready
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // one byte transaction, after an optional random idle stretch
  task automatic send_byte(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= c;
    in_bus.data_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // random byte leaning toward the all-zero and all-one extremes
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return BYTE_W'($urandom_range(255));
  endfunction

  // mid-field bytes mostly carry the field's own command, sometimes another
  // non-end one, which the block must treat as part of the field anyway
  function automatic logic [CMD_W-1:0] tail_cmd(input logic [CMD_W-1:0] home);
    if ($urandom_range(9) == 0) return CMD_W'($urandom_range(2));
    return home;
  endfunction

  // int field: plain byte, 16-bit escape or 32-bit escape;
  // cut >= 0 ends the data after cut % n payload bytes, n being the payload length
  task automatic send_int_field(input int cut);
    int               mode;
    int               n;
    logic [BYTE_W-1:0] b;
    mode = (cut >= 0) ? $urandom_range(1, 2) : $urandom_range(2);
    if (mode == 0) begin
      b = pick_byte();
      if (b == ESC_16 || b == ESC_32) b = b ^ 8'h04;
      send_byte(CMD_INT, b);
      return;
    end
    n = (mode == 1) ? 2 : 4;
    send_byte(CMD_INT, (mode == 1) ? ESC_16 : ESC_32);
    for (int i = 0; i < n; i++) begin
      if (i == cut % n) begin
        if (cut >= 0) begin
          send_byte(CMD_END, pick_byte());
          return;
        end
      end
      send_byte(tail_cmd(CMD_INT), pick_byte());
    end
  endtask

  // uint field of one to four groups; cut >= 0 ends the data mid-field
  task automatic send_uint_field(input int cut);
    int                n;
    int                stop_at;
    logic [BYTE_W-1:0] b;
    n       = (cut >= 0) ? 4 : $urandom_range(1, 4);
    stop_at = (cut >= 0) ? 1 + cut % 3 : n;
    for (int i = 0; i < stop_at; i++) begin
      b = pick_byte();
      if (i == 3) b[7] = 1'($urandom_range(1));   // top fill or not
      else b[7] = (i < n - 1);
      send_byte((i == 0) ? CMD_UINT : tail_cmd(CMD_UINT), b);
    end
    if (cut >= 0) send_byte(CMD_END, pick_byte());
  endtask

  // one random piece of stream: mostly whole fields, some truncated ones,
  // ends while idle and raw noise bytes
  task automatic send_random_piece();
    int pick;
    pick = $urandom_range(99);
    if (pick < 28) send_int_field(-1);
    else if (pick < 58) send_uint_field(-1);
    else if (pick < 68) send_byte(CMD_BOOL, BYTE_W'($urandom_range(1)));
    else if (pick < 76) send_byte(CMD_BOOL, pick_byte());
    else if (pick < 82) send_int_field($urandom_range(3));
    else if (pick < 88) send_uint_field($urandom_range(2));
    else if (pick < 93) send_byte(CMD_END, pick_byte());
    else send_byte(CMD_W'($urandom_range(3)), pick_byte());
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input int upto);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    while (bytes_sent < upto) send_random_piece();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker          = new();
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = CMD_END;
    in_bus.data_byte = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes of every kind and each corner case
    send_byte(CMD_INT, 8'h00);                     // int plain minimum
    send_byte(CMD_INT, 8'hFF);                     // int plain maximum, no sign extension
    send_byte(CMD_INT, ESC_16);                    // 16-bit escape, all ones
    send_byte(CMD_INT, 8'hFF);
    send_byte(CMD_INT, 8'hFF);
    send_byte(CMD_INT, ESC_32);                    // 32-bit escape, sign bit only
    send_byte(CMD_INT, 8'h00);
    send_byte(CMD_INT, 8'h00);
    send_byte(CMD_INT, 8'h00);
    send_byte(CMD_INT, 8'h80);
    send_byte(CMD_UINT, 8'h7F);                    // uint single group maximum
    send_byte(CMD_UINT, 8'hFF);                    // four groups with top fill
    send_byte(CMD_UINT, 8'hFF);
    send_byte(CMD_UINT, 8'hFF);
    send_byte(CMD_UINT, 8'hFF);
    send_byte(CMD_BOOL, 8'h01);
    send_byte(CMD_BOOL, 8'h02);                    // bool above one: invalid data
    send_byte(CMD_END, 8'hA5);                     // end of data while idle: no field
    send_byte(CMD_INT, ESC_32);                    // end of data inside an int escape
    send_byte(CMD_INT, 8'hAA);
    send_byte(CMD_END, 8'h00);
    send_byte(CMD_UINT, 8'h80);                    // end of data inside a uint
    send_byte(CMD_END, 8'hFF);
    send_byte(CMD_INT, ESC_16);                    // escape payload under other commands
    send_byte(CMD_UINT, 8'h34);
    send_byte(CMD_BOOL, 8'h12);
    send_byte(CMD_BOOL, 8'h00);

    // random: sender-light/receiver-heavy idling, then the reverse, then none
    run_phase(7, 83, ITEM_TARGET / 3);
    run_phase(83, 7, 2 * ITEM_TARGET / 3);
    hold_req = 1'b1;                               // receiver goes quiet, sender keeps pushing
    run_phase(0, 0, ITEM_TARGET);

    in_bus.valid <= 1'b0;

    // drain every owed field, then let the pipeline settle
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    tracker.flag_leftovers();

    $display("sent %0d byte transactions; checked %0d fields: %0d ok, %0d cut short, %0d invalid",
             bytes_sent, tracker.checked, tracker.n_ok, tracker.n_eos, tracker.n_bad);
    $display("idling mixes: sender-heavy, receiver-heavy, none, with a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", tracker.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
